@@ sv/hash_join_build_probe_assert.svh @@
// assertion macros shared by the hash join engine
`ifndef HASH_JOIN_BUILD_PROBE_ASSERT_SVH
`define HASH_JOIN_BUILD_PROBE_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define HJBP_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define HJBP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/hjbp_pkg.sv @@
// shared types and constants of the hash join engine
package hjbp_pkg;

  localparam int KEY_W = 32;
  localparam int ROW_W = 32;

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  localparam logic STATUS_MATCH = 1'b0;
  localparam logic STATUS_DROP  = 1'b1;

  // entry store access controls
  typedef struct packed {
    logic rd;
    logic wr;
    logic link;
  } ent_ctl_t;

  // bucket store access controls
  typedef struct packed {
    logic rd;
    logic wr;
  } bkt_ctl_t;

endpackage

@@ sv/hjbp_in_if.sv @@
// input channel: build and probe items
interface hjbp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [hjbp_pkg::KEY_W-1:0]  join_key;
  logic        [hjbp_pkg::ROW_W-1:0]  row_handle;

  modport source (output valid, cmd, join_key, row_handle, input ready);
  modport sink   (input valid, cmd, join_key, row_handle, output ready);
endinterface

@@ sv/hjbp_out_if.sv @@
// output channel: join results and drop reports
interface hjbp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [hjbp_pkg::ROW_W-1:0]   probe_row;
  logic [hjbp_pkg::ROW_W-1:0]   build_row;
  logic                         last;

  modport source (output valid, status, probe_row, build_row, last, input ready);
  modport sink   (input valid, status, probe_row, build_row, last, output ready);
endinterface

@@ sv/hash_join_build_probe.sv @@
// top level of the inner hash join engine with chained bucket store
//
//   channel  dir  beat carries                         accepted when
//   item     in   cmd, join_key, row_handle            item.valid & item.ready
//   result   out  status, probe_row, build_row, last   result.valid & result.ready
//
// build: accept, bucket index, bucket read then entry write, then a link write
//   when the bucket already holds a chain
// probe: accept, bucket index, bucket read, then a walk down the chain that stalls
//   while a held match cannot enter the result register, then a flush of the final match
// a bucket count that is not a power of two adds the steps of the nibble-serial
//   remainder unit
// after reset the bucket memory is swept once before items are taken; a stalled
//   result holds a chain walk, its final flush or a drop report, and the item input
//   stays closed until that item is finished
`include "hash_join_build_probe_assert.svh"

module hash_join_build_probe #(
  parameter int ENTRY_COUNT  = 64,
  parameter int BUCKET_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  hjbp_in_if.sink           item,
  hjbp_out_if.source        result
);
  import hjbp_pkg::*;

  localparam int EW = $clog2(ENTRY_COUNT);
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int FW = $clog2(ENTRY_COUNT + 1);

  localparam logic [FW-1:0] FULL = FW'(ENTRY_COUNT);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_BKT   = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;
  localparam logic [2:0] S_DROP  = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [ROW_W-1:0] row_q;
  logic [FW-1:0]    fill;
  logic [FW-1:0]    fill_next;

  // one match held back so the final one can carry last
  logic             pend_valid;
  logic             pend_valid_next;
  logic [ROW_W-1:0] pend_row;
  logic [ROW_W-1:0] pend_row_next;

  // result register
  logic             res_valid;
  logic             res_status;
  logic [ROW_W-1:0] res_probe;
  logic [ROW_W-1:0] res_build;
  logic             res_last;
  logic             res_load;
  logic             load_status;
  logic [ROW_W-1:0] load_probe;
  logic [ROW_W-1:0] load_build;
  logic             load_last;

  logic             accept;
  logic             out_free;
  logic             match;

  // checker helpers
  logic             in_probe;
  logic             drop_load;
  logic             drop_shown;

  // hash unit
  logic             hash_done;
  logic [BW-1:0]    bucket;

  // bucket store
  bkt_ctl_t         bkt_ctl;
  logic             bkt_ready;
  logic             bkt_valid;
  logic [EW-1:0]    bkt_head;
  logic [EW-1:0]    bkt_tail;
  logic [EW-1:0]    bkt_wr_head;

  // entry store
  ent_ctl_t         ent_ctl;
  logic [EW-1:0]    ent_rd_addr;
  logic [EW-1:0]    ent_wr_addr;
  logic [EW-1:0]    e_idx;
  logic [EW-1:0]    prev_idx;
  logic [KEY_W-1:0] ent_key;
  logic [ROW_W-1:0] ent_row;
  logic             ent_has_next;
  logic [EW-1:0]    ent_next;

  assign item.ready = (state == S_IDLE) && bkt_ready;
  assign accept     = item.valid && item.ready;
  assign out_free   = !res_valid || result.ready;

  // next free entry, and the entry just written once fill has moved on
  assign e_idx       = fill[EW-1:0];
  assign prev_idx    = EW'(fill - FW'(1));
  assign bkt_wr_head = bkt_valid ? bkt_head : e_idx;
  assign match       = (ent_key == key_q);

  hjbp_hash #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .key    (unsigned'(item.join_key)),
    .done   (hash_done),
    .bucket (bucket)
  );

  hjbp_bucket_store #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .ENTRY_COUNT  (ENTRY_COUNT)
  ) u_bucket (
    .clk      (clk),
    .rst      (rst),
    .ctl      (bkt_ctl),
    .addr     (bucket),
    .wr_head  (bkt_wr_head),
    .wr_tail  (e_idx),
    .ready    (bkt_ready),
    .rd_valid (bkt_valid),
    .rd_head  (bkt_head),
    .rd_tail  (bkt_tail)
  );

  hjbp_entry_store #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_entry (
    .clk         (clk),
    .ctl         (ent_ctl),
    .rd_addr     (ent_rd_addr),
    .wr_addr     (ent_wr_addr),
    .wr_key      (key_q),
    .wr_row      (row_q),
    .link_idx    (prev_idx),
    .rd_key      (ent_key),
    .rd_row      (ent_row),
    .rd_has_next (ent_has_next),
    .rd_next     (ent_next)
  );

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    pend_valid_next = pend_valid;
    pend_row_next   = pend_row;
    res_load        = 1'b0;
    load_status     = STATUS_MATCH;
    load_probe      = row_q;
    load_build      = pend_row;
    load_last       = 1'b0;
    bkt_ctl         = '0;
    ent_ctl         = '0;
    ent_rd_addr     = bkt_head;
    ent_wr_addr     = e_idx;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((item.cmd == CMD_BUILD) && (fill == FULL)) begin
            state_next = S_DROP;
          end else begin
            state_next = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bkt_ctl.rd = 1'b1;
          state_next = S_BKT;
        end
      end
      S_BKT: begin
        if (cmd_q == CMD_BUILD) begin
          // new entry at the tail, chain link patched next cycle
          ent_ctl.wr  = 1'b1;
          ent_wr_addr = e_idx;
          bkt_ctl.wr  = 1'b1;
          fill_next   = fill + FW'(1);
          state_next  = bkt_valid ? S_LINK : S_IDLE;
        end else if (bkt_valid) begin
          ent_ctl.rd  = 1'b1;
          ent_rd_addr = bkt_head;
          state_next  = S_WALK;
        end else begin
          state_next  = S_IDLE;
        end
      end
      S_LINK: begin
        ent_ctl.link = 1'b1;
        ent_wr_addr  = bkt_tail;
        state_next   = S_IDLE;
      end
      S_WALK: begin
        // hold the walk while a held match cannot be pushed out
        if (!(match && pend_valid && !out_free)) begin
          if (match) begin
            res_load        = pend_valid;
            pend_valid_next = 1'b1;
            pend_row_next   = ent_row;
          end
          if (ent_has_next) begin
            ent_ctl.rd  = 1'b1;
            ent_rd_addr = ent_next;
          end else begin
            state_next  = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          res_load        = 1'b1;
          load_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      S_DROP: begin
        if (out_free) begin
          res_load    = 1'b1;
          load_status = STATUS_DROP;
          load_probe  = '0;
          load_build  = row_q;
          load_last   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      pend_valid <= pend_valid_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= item.cmd;
      key_q <= unsigned'(item.join_key);
      row_q <= item.row_handle;
    end
    pend_row <= pend_row_next;
    if (res_load) begin
      res_status <= load_status;
      res_probe  <= load_probe;
      res_build  <= load_build;
      res_last   <= load_last;
    end
  end

  assign result.valid     = res_valid;
  assign result.status    = res_status;
  assign result.probe_row = res_probe;
  assign result.build_row = res_build;
  assign result.last      = res_last;

  assign in_probe   = (state == S_WALK) || (state == S_FLUSH);
  assign drop_load  = (state == S_DROP) && out_free;
  assign drop_shown = res_valid && res_last && (res_status == STATUS_DROP);

  `HJBP_ASSERT_IMP(a_fill_bound, 1'b1, fill <= FULL, "fill count beyond store size")
  `HJBP_ASSERT_IMP(a_pend_scope, !in_probe, !pend_valid, "held match outside a probe")
  `HJBP_ASSERT_IMP(a_drop_full, state == S_DROP, fill == FULL, "build dropped with room left")
  `HJBP_ASSERT_IMP(a_build_room, ent_ctl.wr, fill < FULL, "entry write into full store")
  `HJBP_ASSERT_NEXT(a_drop_result, drop_load, drop_shown, "drop report not loaded")

endmodule

@@ sv/hjbp_hash.sv @@
// bucket index unit: key modulo bucket count
module hjbp_hash #(
  parameter int BUCKET_COUNT = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hjbp_pkg::KEY_W-1:0]       key,
  output logic                             done,
  output logic [$clog2(BUCKET_COUNT)-1:0]  bucket
);
  import hjbp_pkg::*;

  localparam int BW   = $clog2(BUCKET_COUNT);
  localparam bit POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      logic          done_q;
      logic [BW-1:0] rem_q;

      always_ff @(posedge clk) begin
        if (rst) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_q <= key[BW-1:0];
        end
      end

      assign done   = done_q;
      assign bucket = rem_q;
    end else begin : g_iter
      // radix-16 restoring remainder, one nibble a cycle
      localparam int RW    = BW + 4;
      localparam int STEPS = KEY_W / 4;
      localparam int CW    = $clog2(STEPS);

      logic             busy;
      logic             done_q;
      logic [CW-1:0]    cnt;
      logic [KEY_W-1:0] shreg;
      logic [BW-1:0]    rem_q;
      logic [BW-1:0]    rem_next;
      logic [RW-1:0]    wide;

      always_comb begin
        wide = {rem_q, shreg[KEY_W-1 -: 4]};
        for (int k = 3; k >= 0; k--) begin
          if (wide >= (RW'(BUCKET_COUNT) << k)) begin
            wide = wide - (RW'(BUCKET_COUNT) << k);
          end
        end
        rem_next = wide[BW-1:0];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy   <= 1'b0;
          done_q <= 1'b0;
          cnt    <= '0;
        end else if (start) begin
          busy   <= 1'b1;
          done_q <= 1'b0;
          cnt    <= '0;
        end else begin
          done_q <= busy && (cnt == CW'(STEPS - 1));
          if (busy) begin
            cnt <= cnt + 1'b1;
            if (cnt == CW'(STEPS - 1)) begin
              busy <= 1'b0;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          shreg <= key;
          rem_q <= '0;
        end else if (busy) begin
          shreg <= shreg << 4;
          rem_q <= rem_next;
        end
      end

      assign done   = done_q;
      assign bucket = rem_q;
    end
  endgenerate

endmodule

@@ sv/hjbp_entry_store.sv @@
// entry memory: key, build row and chain link per entry
module hjbp_entry_store #(
  parameter int ENTRY_COUNT = 64
) (
  input  logic                            clk,
  input  hjbp_pkg::ent_ctl_t              ctl,
  input  logic [$clog2(ENTRY_COUNT)-1:0]  rd_addr,
  input  logic [$clog2(ENTRY_COUNT)-1:0]  wr_addr,
  input  logic [hjbp_pkg::KEY_W-1:0]      wr_key,
  input  logic [hjbp_pkg::ROW_W-1:0]      wr_row,
  input  logic [$clog2(ENTRY_COUNT)-1:0]  link_idx,
  output logic [hjbp_pkg::KEY_W-1:0]      rd_key,
  output logic [hjbp_pkg::ROW_W-1:0]      rd_row,
  output logic                            rd_has_next,
  output logic [$clog2(ENTRY_COUNT)-1:0]  rd_next
);
  import hjbp_pkg::*;

  localparam int EW = $clog2(ENTRY_COUNT);
  localparam int WW = KEY_W + ROW_W + 1 + EW;

  // word layout: key, row, link valid, link index
  logic [WW-1:0] mem [ENTRY_COUNT];
  logic [WW-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= {wr_key, wr_row, 1'b0, {EW{1'b0}}};
    end else if (ctl.link) begin
      mem[wr_addr][EW:0] <= {1'b1, link_idx};
    end
    if (ctl.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_key      = rd_q[WW-1 -: KEY_W];
  assign rd_row      = rd_q[EW+1 +: ROW_W];
  assign rd_has_next = rd_q[EW];
  assign rd_next     = rd_q[EW-1:0];

endmodule

@@ sv/hjbp_bucket_store.sv @@
// bucket memory: head and tail per chain, cleared after reset
module hjbp_bucket_store #(
  parameter int BUCKET_COUNT = 16,
  parameter int ENTRY_COUNT  = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hjbp_pkg::bkt_ctl_t               ctl,
  input  logic [$clog2(BUCKET_COUNT)-1:0]  addr,
  input  logic [$clog2(ENTRY_COUNT)-1:0]   wr_head,
  input  logic [$clog2(ENTRY_COUNT)-1:0]   wr_tail,
  output logic                             ready,
  output logic                             rd_valid,
  output logic [$clog2(ENTRY_COUNT)-1:0]   rd_head,
  output logic [$clog2(ENTRY_COUNT)-1:0]   rd_tail
);
  import hjbp_pkg::*;

  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int EW = $clog2(ENTRY_COUNT);
  localparam int WW = 1 + 2 * EW;

  logic [WW-1:0] mem [BUCKET_COUNT];
  logic [WW-1:0] rd_q;
  logic          clearing;
  logic [BW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == BW'(BUCKET_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr) begin
      mem[addr] <= {1'b1, wr_head, wr_tail};
    end
    if (ctl.rd) begin
      rd_q <= mem[addr];
    end
  end

  assign ready    = !clearing;
  assign rd_valid = rd_q[WW-1];
  assign rd_head  = rd_q[2*EW-1 -: EW];
  assign rd_tail  = rd_q[EW-1:0];

endmodule

@@ verif/tb_hash_join_build_probe.sv @@
// self-checking testbench for the hash join build and probe engine
`timescale 1ns / 1ps

module tb_hash_join_build_probe;
  import hjbp_pkg::*;

  // block configuration under test
  localparam int ENTRIES = 64;
  localparam int BUCKETS = 16;
  localparam logic [6:0] NO_ENTRY = 7'd127;

  // stimulus sizing
  localparam int RAND_ITEMS  = 120;
  localparam int FAST_FIRST  = 60;   // random items from here to FAST_LAST are offered back to back
  localparam int FAST_LAST   = 89;
  localparam int LONG_HOLD   = 300;  // receiver hold-off that backs the block up
  localparam int QUIET_LIMIT = 5000; // cycles with no beat on either side before giving up
  localparam int DRAIN_WAIT  = 150;  // covers the longest chain walk plus flush
  localparam int POOL_SIZE   = 8;

  typedef struct {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] row;
    int unsigned      gap;
  } join_item_t;

  typedef struct {
    logic             status;
    logic [ROW_W-1:0] probe_row;
    logic [ROW_W-1:0] build_row;
    logic             last;
  } join_res_t;

  logic clk;
  logic rst;

  hjbp_in_if  item_ch ();
  hjbp_out_if result_ch ();

  hash_join_build_probe #(
    .ENTRY_COUNT  (ENTRIES),
    .BUCKET_COUNT (BUCKETS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // items waiting to be offered, and results the block still owes us
  join_item_t item_q[$];
  join_res_t  pending_matches[$];

  // our own picture of the chained store
  logic [KEY_W-1:0] tbl_key  [ENTRIES];
  logic [ROW_W-1:0] tbl_row  [ENTRIES];
  logic [6:0]       tbl_link [ENTRIES];
  logic [6:0]       chain_head [BUCKETS];
  logic [6:0]       chain_tail [BUCKETS];
  int unsigned      tbl_fill;

  // run bookkeeping
  int unsigned beats_in;
  int unsigned mismatches;
  int unsigned n_builds, n_probes, n_hits, n_drops;

  // sender state, owned by the driver
  join_item_t  cur_item;
  bit          offering;
  bit          gap_loaded;
  int unsigned gap_left;

  // receiver state, owned by the monitor
  bit          rx_fast;
  bit          long_hold_req;
  bit          long_hold_taken;
  int unsigned stall_left;

  int unsigned quiet_cycles;

  // clock, and every block input at a known value from time zero
  initial begin
    clk = 1'b0;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_BUILD;
    item_ch.join_key   = '0;
    item_ch.row_handle = '0;
    result_ch.ready    = 1'b0;
    forever #2 clk = ~clk;
  end

  // store update on build, chain walk on probe; expected beats go to the back
  // of pending_matches in the order the block must return them
  task automatic predict_join(input join_item_t it);
    int unsigned bkt;
    int unsigned cur;
    int unsigned steps;
    join_res_t   hits[$];
    join_res_t   r;
    begin
      bkt = it.key % BUCKETS;
      if (it.cmd == CMD_BUILD) begin
        n_builds++;
        if (tbl_fill >= ENTRIES) begin
          // store full: the build is dropped and reported once
          r.status    = STATUS_DROP;
          r.probe_row = '0;
          r.build_row = it.row;
          r.last      = 1'b1;
          pending_matches = {pending_matches, r};
          n_drops++;
        end else begin
          tbl_key[tbl_fill]  = it.key;
          tbl_row[tbl_fill]  = it.row;
          tbl_link[tbl_fill] = NO_ENTRY;
          // append at the tail so duplicates come back in build order
          if (chain_head[bkt] == NO_ENTRY)
            chain_head[bkt] = tbl_fill[6:0];
          else
            tbl_link[chain_tail[bkt] % ENTRIES] = tbl_fill[6:0];
          chain_tail[bkt] = tbl_fill[6:0];
          tbl_fill++;
        end
      end else begin
        n_probes++;
        cur   = chain_head[bkt];
        steps = 0;
        while (cur != NO_ENTRY && cur < ENTRIES && steps < tbl_fill) begin
          if (tbl_key[cur] == it.key && hits.size() < ENTRIES) begin
            r.status    = STATUS_MATCH;
            r.probe_row = it.row;
            r.build_row = tbl_row[cur];
            r.last      = 1'b0;
            hits = {hits, r};
          end
          cur = tbl_link[cur];
          steps++;
        end
        // a probe with no match owes nothing
        if (hits.size() > 0) begin
          hits[hits.size() - 1].last = 1'b1;
        end
        n_hits += hits.size();
        pending_matches = {pending_matches, hits};
      end
    end
  endtask

  task automatic queue_item(input logic cmd, input logic [KEY_W-1:0] key,
                            input logic [ROW_W-1:0] row, input int unsigned gap);
    join_item_t it;
    begin
      it.cmd = cmd;
      it.key = key;
      it.row = row;
      it.gap = gap;
      item_q = {item_q, it};
    end
  endtask

  // driver: waits out each item's gap, then holds valid until the beat is taken;
  // a back-to-back item keeps valid high with a single assignment per edge
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      offering   = 1'b0;
      gap_loaded = 1'b0;
      gap_left   = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_join(cur_item);
        beats_in++;
        offering = 1'b0;
      end
      if (!offering && item_q.size() > 0) begin
        if (!gap_loaded) begin
          gap_left   = item_q[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left == 0) begin
          cur_item   = item_q.pop_front();
          offering   = 1'b1;
          gap_loaded = 1'b0;
          item_ch.cmd        <= cur_item.cmd;
          item_ch.join_key   <= cur_item.key;
          item_ch.row_handle <= cur_item.row;
        end else begin
          gap_left--;
        end
      end
      item_ch.valid <= offering;
    end
  end

  // monitor: checks every result beat against the oldest expectation, then
  // draws its own stall; one long hold-off is counted here on request
  always @(posedge clk) begin
    join_res_t want;
    bit        rdy;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      = 0;
      long_hold_taken = 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_matches.size() == 0) begin
          $error("result beat with nothing expected: status %0d build_row %h",
                 result_ch.status, result_ch.build_row);
          mismatches++;
        end else begin
          want = pending_matches.pop_front();
          if (result_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_ch.status);
            mismatches++;
          end
          if (result_ch.probe_row !== want.probe_row) begin
            $error("probe_row: expected %h, got %h", want.probe_row, result_ch.probe_row);
            mismatches++;
          end
          if (result_ch.build_row !== want.build_row) begin
            $error("build_row: expected %h, got %h", want.build_row, result_ch.build_row);
            mismatches++;
          end
          if (result_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result_ch.last);
            mismatches++;
          end
        end
        stall_left = rx_fast ? 0 : $urandom_range(0, 12);
      end
      if (long_hold_req && !long_hold_taken) begin
        stall_left      = LONG_HOLD;
        long_hold_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      result_ch.ready <= rdy;
    end
  end

  // watchdog: too long with no beat on either channel means the block hung
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    logic             c;
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    int unsigned      g;

    beats_in   = 0;
    mismatches = 0;
    n_builds   = 0;
    n_probes   = 0;
    n_hits     = 0;
    n_drops    = 0;
    tbl_fill   = 0;
    rx_fast       = 1'b0;
    long_hold_req = 1'b0;
    for (int b = 0; b < BUCKETS; b++) begin
      chain_head[b] = NO_ENTRY;
      chain_tail[b] = '0;
    end

    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part: extreme keys and handles, duplicates sharing one chain,
    // an unrelated key in the same bucket, misses on empty and occupied buckets
    queue_item(CMD_PROBE, 32'h0000_0000, 32'h0000_0001, $urandom_range(0, 12));
    queue_item(CMD_BUILD, 32'h0000_0000, 32'h0000_0000, $urandom_range(0, 12));
    queue_item(CMD_BUILD, 32'hffff_ffff, 32'hffff_ffff, $urandom_range(0, 12));
    queue_item(CMD_BUILD, 32'h8000_0000, 32'h0000_0001, $urandom_range(0, 12));
    queue_item(CMD_BUILD, 32'h7fff_ffff, 32'h8000_0000, $urandom_range(0, 12));
    queue_item(CMD_BUILD, 32'h0000_0000, 32'h1234_5678, 0);
    queue_item(CMD_BUILD, 32'h0000_0010, 32'h0000_0005, 0);
    queue_item(CMD_BUILD, 32'h0000_0000, 32'hdead_beef, $urandom_range(0, 12));
    // three duplicates of key zero with key sixteen wedged between them
    queue_item(CMD_PROBE, 32'h0000_0000, 32'hffff_ffff, $urandom_range(0, 12));
    queue_item(CMD_PROBE, 32'h0000_0010, 32'h0000_0000, 0);
    queue_item(CMD_PROBE, 32'hffff_ffff, 32'h5555_aaaa, $urandom_range(0, 12));
    queue_item(CMD_PROBE, 32'h8000_0000, 32'haaaa_5555, 0);
    queue_item(CMD_PROBE, 32'h7fff_ffff, 32'h7fff_ffff, $urandom_range(0, 12));
    queue_item(CMD_PROBE, 32'h0000_0030, 32'h0000_0030, $urandom_range(0, 12));
    queue_item(CMD_PROBE, 32'h0000_0001, 32'h0000_0001, $urandom_range(0, 12));
    queue_item(CMD_PROBE, 32'h0000_0000, 32'h0f0f_0f0f, 0);

    // sender pause: nothing more goes in until every owed result is back
    while (item_q.size() != 0 || offering) @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);

    // key pool: one hot key for long duplicate chains, one key sharing its
    // bucket, the extremes, and a few random patterns
    key_pool[0] = $urandom;
    key_pool[1] = 32'h0000_0000;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'h7fff_ffff;
    key_pool[5] = $urandom;
    key_pool[6] = $urandom;
    key_pool[7] = ($urandom & 32'hffff_fff0) | (key_pool[0] & 32'h0000_000f);

    // random part: builds outweigh probes so the store fills and later builds
    // get dropped; most keys come from the pool so probes find matches
    for (int i = 0; i < RAND_ITEMS; i++) begin
      c    = ($urandom_range(0, 99) < 60) ? CMD_BUILD : CMD_PROBE;
      pick = $urandom_range(0, 99);
      if (pick < 30)
        k = key_pool[0];
      else if (pick < 85)
        k = key_pool[$urandom_range(1, POOL_SIZE - 1)];
      else
        k = $urandom;
      g = (i >= FAST_FIRST && i <= FAST_LAST) ? 0 : $urandom_range(0, 12);
      queue_item(c, k, $urandom, g);
    end

    // a stretch with no idling on either side
    while (beats_in < 16 + FAST_FIRST) @(posedge clk);
    rx_fast <= 1'b1;
    while (beats_in < 16 + FAST_LAST) @(posedge clk);
    rx_fast <= 1'b0;

    // long receiver hold-off while the sender keeps offering
    while (beats_in < 16 + FAST_LAST + 6) @(posedge clk);
    long_hold_req <= 1'b1;

    while (item_q.size() != 0 || offering) @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (pending_matches.size() != 0) begin
      $error("%0d expected results never arrived", pending_matches.size());
      mismatches++;
    end

    $display("covered %0d builds (%0d dropped on a full store) and %0d probes",
             n_builds, n_drops, n_probes);
    $display("checked %0d join matches, %0d field mismatches", n_hits, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/hjbp_pkg.sv
sv/hjbp_in_if.sv
sv/hjbp_out_if.sv
sv/hjbp_hash.sv
sv/hjbp_entry_store.sv
sv/hjbp_bucket_store.sv
sv/hash_join_build_probe.sv
verif/tb_hash_join_build_probe.sv
